// File: sv/lcgsbc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lcg substitution byte cipher
// no dependencies
package lcgsbc_pkg;

  localparam int ALPHABET   = 256;
  localparam int IDX_W      = $clog2(ALPHABET);
  localparam int SEED_W     = 32;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'h0808_8405;
  localparam logic [SEED_W-1:0] LCG_INC = 32'h0000_0001;

  localparam logic [SEED_W-1:0] TABLE_SEED_RST = 32'd6011979;
  localparam logic [ITER_W-1:0] TABLE_ITER_RST = 16'd1024;
  localparam logic [SEED_W-1:0] STREAM_SEED_RST = 32'd24031979;

  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(ALPHABET - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ITER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_SEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd3;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_DATA  = 1'b1;
  localparam logic DIR_DECODE = 1'b1;

  typedef enum logic [2:0] {
    LCG_HOLD,
    LCG_SHUF_LOAD,
    LCG_SHUF_STEP,
    LCG_KEY_STEP,
    LCG_KEY_RESTART
  } lcg_op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_INV,
    ST_INV_TAIL,
    ST_BUILD_OUT,
    ST_DATA_KEY,
    ST_DATA_RD,
    ST_DATA_OUT
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] data;
    logic             msg_start;
    logic             msg_end;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] data;
    logic             end_flag;
    logic             build_done;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: sv/lcgsbc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module lcgsbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lcgsbc_lcg.sv
`timescale 1ns / 1ps
// shared lcg step unit holding the shuffle and keystream seeds
// depends on lcgsbc_pkg
module lcgsbc_lcg (
  input  logic                           clk,
  input  logic                           rst,
  input  lcgsbc_pkg::lcg_op_t            op,
  input  logic [lcgsbc_pkg::SEED_W-1:0]  table_seed,
  input  logic [lcgsbc_pkg::SEED_W-1:0]  stream_seed,
  output logic [lcgsbc_pkg::IDX_W-1:0]   next_top,
  output logic [lcgsbc_pkg::IDX_W-1:0]   key_byte
);
  import lcgsbc_pkg::*;

  logic [SEED_W-1:0] shuf_seed;
  logic [SEED_W-1:0] ks_seed;
  logic [SEED_W-1:0] src;
  logic [SEED_W-1:0] product;
  logic [SEED_W-1:0] stepped;

  always_comb begin
    case (op)
      LCG_KEY_RESTART: src = stream_seed;
      LCG_SHUF_STEP:   src = shuf_seed;
      default:         src = ks_seed;
    endcase
  end

  assign product  = src * LCG_MUL;
  assign stepped  = product + LCG_INC;
  assign next_top = stepped[SEED_W-1 -: IDX_W];
  assign key_byte = ks_seed[SEED_W-1 -: IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      shuf_seed <= '0;
      ks_seed   <= '0;
    end else begin
      case (op)
        LCG_SHUF_LOAD:   shuf_seed <= table_seed;
        LCG_SHUF_STEP:   shuf_seed <= stepped;
        LCG_KEY_STEP:    ks_seed   <= stepped;
        LCG_KEY_RESTART: ks_seed   <= stepped;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/lcgsbc_ctrl.sv
`timescale 1ns / 1ps
// sequencer: table clearing sweep, swap shuffle, inverse derivation, byte path
// depends on lcgsbc_pkg
module lcgsbc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  lcgsbc_pkg::item_t             item,
  input  logic [lcgsbc_pkg::ITER_W-1:0] table_iterations,
  input  logic                          direction,
  output lcgsbc_pkg::lcg_op_t           lcg_op,
  input  logic [lcgsbc_pkg::IDX_W-1:0]  next_top,
  input  logic [lcgsbc_pkg::IDX_W-1:0]  key_byte,
  output lcgsbc_pkg::ram_req_t          fwd_req,
  input  logic [lcgsbc_pkg::IDX_W-1:0]  fwd_rdata,
  output lcgsbc_pkg::ram_req_t          inv_req,
  input  logic [lcgsbc_pkg::IDX_W-1:0]  inv_rdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lcgsbc_pkg::result_t           res
);
  import lcgsbc_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  cnt;
  logic [ITER_W-1:0] iter_cnt;
  logic [IDX_W-1:0]  idx_a;
  logic [IDX_W-1:0]  idx_b;
  logic [IDX_W-1:0]  val_a;
  logic [IDX_W-1:0]  inv_idx;
  logic              inv_pend;
  logic              building;
  item_t             cur;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.kind == KIND_DATA) ? ST_DATA_KEY : ST_INIT;
        end
      end
      ST_INIT: begin
        if (cnt == CNT_LAST) begin
          if (!building) begin
            state_next = ST_IDLE;
          end else if (iter_cnt == '0) begin
            state_next = ST_INV;
          end else begin
            state_next = ST_DRAW_A;
          end
        end
      end
      ST_DRAW_A: state_next = ST_DRAW_B;
      ST_DRAW_B: begin
        if (next_top != idx_a) begin
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_WR_A;
      ST_WR_A: state_next = ST_WR_B;
      ST_WR_B: state_next = (iter_cnt == ITER_W'(1)) ? ST_INV : ST_DRAW_A;
      ST_INV: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_INV_TAIL;
        end
      end
      ST_INV_TAIL: state_next = ST_BUILD_OUT;
      ST_BUILD_OUT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_DATA_KEY: state_next = ST_DATA_RD;
      ST_DATA_RD:  state_next = ST_DATA_OUT;
      ST_DATA_OUT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = 1'b0;
    lcg_op    = LCG_HOLD;
    fwd_req   = '0;
    inv_req   = '0;
    res_valid = 1'b0;
    res       = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && item.kind == KIND_BUILD) begin
          lcg_op = LCG_SHUF_LOAD;
        end
      end
      ST_INIT: begin
        fwd_req.we    = 1'b1;
        fwd_req.waddr = cnt;
        fwd_req.wdata = cnt;
        inv_req.we    = 1'b1;
        inv_req.waddr = cnt;
        inv_req.wdata = cnt;
      end
      ST_DRAW_A: lcg_op = LCG_SHUF_STEP;
      ST_DRAW_B: lcg_op = LCG_SHUF_STEP;
      ST_RD_A: begin
        fwd_req.re    = 1'b1;
        fwd_req.raddr = idx_a;
      end
      ST_RD_B: begin
        fwd_req.re    = 1'b1;
        fwd_req.raddr = idx_b;
      end
      ST_WR_A: begin
        fwd_req.we    = 1'b1;
        fwd_req.waddr = idx_a;
        fwd_req.wdata = fwd_rdata;
      end
      ST_WR_B: begin
        fwd_req.we    = 1'b1;
        fwd_req.waddr = idx_b;
        fwd_req.wdata = val_a;
      end
      ST_INV: begin
        fwd_req.re    = 1'b1;
        fwd_req.raddr = cnt;
      end
      ST_BUILD_OUT: begin
        res_valid      = 1'b1;
        res.build_done = 1'b1;
      end
      ST_DATA_KEY: lcg_op = cur.msg_start ? LCG_KEY_RESTART : LCG_KEY_STEP;
      ST_DATA_RD: begin
        if (direction == DIR_DECODE) begin
          inv_req.re    = 1'b1;
          inv_req.raddr = cur.data ^ key_byte;
        end else begin
          fwd_req.re    = 1'b1;
          fwd_req.raddr = cur.data;
        end
      end
      ST_DATA_OUT: begin
        res_valid    = 1'b1;
        res.data     = (direction == DIR_DECODE) ? inv_rdata : (fwd_rdata ^ key_byte);
        res.end_flag = cur.msg_end;
      end
      default: ;
    endcase
    // inverse entry write comes in the cycle after its forward read
    if (inv_pend) begin
      inv_req.we    = 1'b1;
      inv_req.waddr = fwd_rdata;
      inv_req.wdata = inv_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      building <= 1'b0;
      inv_pend <= 1'b0;
    end else begin
      state    <= state_next;
      inv_pend <= (state == ST_INV);
      case (state)
        ST_IDLE: begin
          if (accept && item.kind == KIND_BUILD) begin
            building <= 1'b1;
            cnt      <= '0;
          end
        end
        ST_INIT: cnt <= cnt + 1'b1;
        ST_INV:  cnt <= cnt + 1'b1;
        ST_BUILD_OUT: begin
          if (res_ready) begin
            building <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur      <= item;
          iter_cnt <= table_iterations;
        end
      end
      ST_DRAW_A: idx_a    <= next_top;
      ST_DRAW_B: idx_b    <= next_top;
      ST_RD_B:   val_a    <= fwd_rdata;
      ST_WR_B:   iter_cnt <= iter_cnt - 1'b1;
      ST_INV:    inv_idx  <= cnt;
      default: ;
    endcase
  end

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_tready)
    else $error("input accepted while a result is pending");

  a_swap_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_A) |-> (idx_a != idx_b))
    else $error("swap indices are equal");

  a_swap_no_inv_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_A || state == ST_WR_B) |-> !inv_req.we)
    else $error("inverse table written during a swap");

  a_data_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && item.kind == KIND_DATA) |-> ##3 res_valid)
    else $error("data result not ready three cycles after transfer");

endmodule

// File: sv/lcg_substitution_byte_cipher.sv
`timescale 1ns / 1ps
// top level of the lcg substitution byte cipher: config registers, output register
// depends on lcgsbc_pkg, lcgsbc_ram, lcgsbc_lcg, lcgsbc_ctrl
//
// input stream s_*: tdata is the byte, tuser[0] the kind (0 rebuild tables,
// 1 data byte), tuser[1] message start, tlast message end. output stream m_*:
// tdata the processed byte (zero for a rebuild), tlast copies message end,
// tuser is set on the rebuild acknowledgement. every input transfer gives
// exactly one output transfer, in order.
// a data byte passes the keystream lcg step and the registered table read before
// it reaches the output register; these set the pace, and the next byte is taken
// only once the last byte's result has moved into the output register.
// a rebuild sweeps the tables to identity, then for each swap draws two indices
// (the second redrawn until it differs), reads both entries and writes them back
// swapped, then derives the inverse table from the forward one.
// after reset a clearing pass loads identity tables; no input is taken meanwhile,
// configuration writes are. when the receiver stalls, the result waits in the output
// register and the block takes one more item and holds its result until the register
// frees.
module lcg_substitution_byte_cipher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // data_in
  input  logic [1:0]                        s_tuser,  // kind, message_start
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,  // data_out
  output logic                              m_tuser,  // build_done
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [lcgsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcgsbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcgsbc_pkg::*;

  logic [SEED_W-1:0] table_seed;
  logic [ITER_W-1:0] table_iterations;
  logic [SEED_W-1:0] stream_seed;
  logic              direction;

  item_t             item;
  lcg_op_t           lcg_op;
  logic [IDX_W-1:0]  next_top;
  logic [IDX_W-1:0]  key_byte;
  ram_req_t          fwd_req;
  ram_req_t          inv_req;
  logic [IDX_W-1:0]  fwd_rdata;
  logic [IDX_W-1:0]  inv_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_seed       <= TABLE_SEED_RST;
      table_iterations <= TABLE_ITER_RST;
      stream_seed      <= STREAM_SEED_RST;
      direction        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_SEED:  table_seed       <= cfg_data[SEED_W-1:0];
        CFG_TABLE_ITER:  table_iterations <= cfg_data[ITER_W-1:0];
        CFG_STREAM_SEED: stream_seed      <= cfg_data[SEED_W-1:0];
        CFG_DIRECTION:   direction        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item.kind      = s_tuser[0];
  assign item.data      = s_tdata;
  assign item.msg_start = s_tuser[1];
  assign item.msg_end   = s_tlast;

  lcgsbc_lcg u_lcg (
    .clk         (clk),
    .rst         (rst),
    .op          (lcg_op),
    .table_seed  (table_seed),
    .stream_seed (stream_seed),
    .next_top    (next_top),
    .key_byte    (key_byte)
  );

  lcgsbc_ram #(.WIDTH(IDX_W), .DEPTH(ALPHABET)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_req.we),
    .waddr (fwd_req.waddr),
    .wdata (fwd_req.wdata),
    .re    (fwd_req.re),
    .raddr (fwd_req.raddr),
    .rdata (fwd_rdata)
  );

  lcgsbc_ram #(.WIDTH(IDX_W), .DEPTH(ALPHABET)) u_inv_ram (
    .clk   (clk),
    .we    (inv_req.we),
    .waddr (inv_req.waddr),
    .wdata (inv_req.wdata),
    .re    (inv_req.re),
    .raddr (inv_req.raddr),
    .rdata (inv_rdata)
  );

  lcgsbc_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .item             (item),
    .table_iterations (table_iterations),
    .direction        (direction),
    .lcg_op           (lcg_op),
    .next_top         (next_top),
    .key_byte         (key_byte),
    .fwd_req          (fwd_req),
    .fwd_rdata        (fwd_rdata),
    .inv_req          (inv_req),
    .inv_rdata        (inv_rdata),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res.data;
      m_tlast <= res.end_flag;
      m_tuser <= res.build_done;
    end
  end

endmodule

// File: verif/lcgsbc_checker.sv
`timescale 1ns / 1ps
// result checker for the lcg substitution byte cipher: watches the config port and both
// streams, keeps its own copy of the tables and seeds, and scores every output transfer
// depends on lcgsbc_pkg
module lcgsbc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_in
  input  logic [1:0]                        s_tuser,   // kind, message_start
  input  logic                              s_tlast,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [7:0]                        m_tdata,   // data_out
  input  logic                              m_tuser,   // build_done
  input  logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [lcgsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcgsbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                       mismatch_count,
  output int unsigned                       results_waiting,
  output int unsigned                       results_checked
);
  import lcgsbc_pkg::*;

  localparam int unsigned REPORT_CAP = 40;

  logic [IDX_W-1:0]  sbox     [ALPHABET];
  logic [IDX_W-1:0]  sbox_inv [ALPHABET];
  logic [SEED_W-1:0] key_seed;
  logic [SEED_W-1:0] shuf_seed;
  logic [SEED_W-1:0] tbl_seed;
  logic [SEED_W-1:0] strm_seed;
  logic [ITER_W-1:0] tbl_iters;
  logic              dir;
  result_t           byte_results_q [$];
  int unsigned       errs;
  int unsigned       seen;
  int unsigned       reports;

  function automatic logic [SEED_W-1:0] lcg_advance(input logic [SEED_W-1:0] s);
    return s * LCG_MUL + LCG_INC;
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < ALPHABET; i++) begin
      sbox[i]     = IDX_W'(i);
      sbox_inv[i] = IDX_W'(i);
    end
  endfunction

  function automatic void shuffle_sbox();
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] t;
    load_identity();
    shuf_seed = tbl_seed;
    for (int n = 0; n < int'(tbl_iters); n++) begin
      shuf_seed = lcg_advance(shuf_seed);
      a = shuf_seed[SEED_W-1 -: IDX_W];
      shuf_seed = lcg_advance(shuf_seed);
      b = shuf_seed[SEED_W-1 -: IDX_W];
      // second index is redrawn until it differs
      while (a == b) begin
        shuf_seed = lcg_advance(shuf_seed);
        b = shuf_seed[SEED_W-1 -: IDX_W];
      end
      t       = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = t;
    end
    for (int i = 0; i < ALPHABET; i++) sbox_inv[sbox[i]] = IDX_W'(i);
  endfunction

  function automatic result_t cipher_step(input item_t it);
    result_t          r;
    logic [IDX_W-1:0] key;
    r = '0;
    if (it.kind == KIND_BUILD) begin
      shuffle_sbox();
      r.build_done = 1'b1;
    end else begin
      if (it.msg_start) key_seed = strm_seed;
      key_seed   = lcg_advance(key_seed);
      key        = key_seed[SEED_W-1 -: IDX_W];
      r.data     = (dir == DIR_DECODE) ? sbox_inv[it.data ^ key] : (sbox[it.data] ^ key);
      r.end_flag = it.msg_end;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errs++;
      if (reports < REPORT_CAP) begin
        reports++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    if (rst) begin
      load_identity();
      key_seed  = '0;
      shuf_seed = '0;
      tbl_seed  = TABLE_SEED_RST;
      tbl_iters = TABLE_ITER_RST;
      strm_seed = STREAM_SEED_RST;
      dir       = 1'b0;
      byte_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_SEED:  tbl_seed  = cfg_data;
          CFG_TABLE_ITER:  tbl_iters = cfg_data[ITER_W-1:0];
          CFG_STREAM_SEED: strm_seed = cfg_data;
          CFG_DIRECTION:   dir       = cfg_data[0];
          default: ;
        endcase
      end
      // a result can never leave on the edge its own item enters
      if (m_tvalid && m_tready) begin
        seen++;
        if (byte_results_q.size() == 0) begin
          errs++;
          if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: unexpected result, expected none, got data %02h end %0b build %0b",
                     $time, m_tdata, m_tlast, m_tuser);
          end
        end else begin
          want = byte_results_q.pop_front();
          check_field("data_out", want.data, m_tdata);
          check_field("end_flag", want.end_flag, m_tlast);
          check_field("build_done", want.build_done, m_tuser);
        end
      end
      if (s_tvalid && s_tready) begin
        it.kind      = s_tuser[0];
        it.data      = s_tdata;
        it.msg_start = s_tuser[1];
        it.msg_end   = s_tlast;
        byte_results_q.push_back(cipher_step(it));
      end
    end
    mismatch_count  <= errs;
    results_waiting <= byte_results_q.size();
    results_checked <= seen;
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the lcg substitution byte cipher: clock, reset, config writes,
// stream stimulus with idle and stall phases, watchdog and verdict
// depends on lcgsbc_pkg, lcg_substitution_byte_cipher, lcgsbc_checker
module tb_top;
  import lcgsbc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1_200_000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned ITEM_TARGET    = 950;
  localparam int unsigned DIRECTED_ITEMS = 15;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam logic        DIR_ENCODE     = ~DIR_DECODE;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // data_in
  logic [1:0]            s_tuser;   // kind, message_start
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // data_out
  logic                  m_tuser;   // build_done
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned results_waiting;
  int unsigned results_checked;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned items_sent;
  int unsigned builds_sent;
  int unsigned quiet_cycles;

  lcg_substitution_byte_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcgsbc_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_seen;
    hold_seen = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        m_tready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] data, input logic first,
                           input logic last);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = data;
    s_tuser  = {first, kind};
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (kind == KIND_BUILD) builds_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (results_waiting != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic write_all_regs(input logic [31:0] tseed, input logic [15:0] iters,
                                input logic [31:0] sseed, input logic dir);
    write_reg(CFG_TABLE_SEED, tseed);
    write_reg(CFG_TABLE_ITER, CFG_DATA_W'(iters));
    write_reg(CFG_STREAM_SEED, sseed);
    write_reg(CFG_DIRECTION, CFG_DATA_W'(dir));
  endtask

  task automatic send_message();
    int unsigned len;
    logic        first;
    logic        last;
    len = $urandom_range(1, 12);
    for (int unsigned i = 0; i < len; i++) begin
      first = (i == 0);
      last  = (i == len - 1);
      // occasional broken framing
      if ($urandom_range(99) < 8) first = ~first;
      if ($urandom_range(99) < 8) last = ~last;
      send_item(KIND_DATA, 8'($urandom_range(255)), first, last);
    end
  endtask

  initial begin
    int unsigned pick;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    s_tlast     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_req    = 0;
    items_sent  = 0;
    builds_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity tables and zero keystream seed before any build or message start
    send_item(KIND_DATA, 8'h00, 1'b0, 1'b0);
    send_item(KIND_DATA, 8'hff, 1'b0, 1'b1);
    send_item(KIND_DATA, 8'ha5, 1'b1, 1'b0);
    send_item(KIND_DATA, 8'h5a, 1'b1, 1'b1);
    // build with the reset key set, ignored fields set
    send_item(KIND_BUILD, 8'hff, 1'b1, 1'b1);
    send_item(KIND_DATA, 8'h00, 1'b1, 1'b0);
    send_item(KIND_DATA, 8'hff, 1'b0, 1'b1);
    drain_results();
    write_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_DECODE));
    send_item(KIND_DATA, 8'h3c, 1'b1, 1'b0);
    send_item(KIND_DATA, 8'hc3, 1'b0, 1'b1);
    // zero iterations keeps identity
    drain_results();
    write_all_regs(32'h0000_0000, 16'h0000, 32'h0000_0000, DIR_ENCODE);
    send_item(KIND_BUILD, 8'h00, 1'b0, 1'b0);
    send_item(KIND_DATA, 8'h12, 1'b1, 1'b0);
    send_item(KIND_DATA, 8'hed, 1'b0, 1'b1);
    // longest build, all-ones seeds
    drain_results();
    write_all_regs(32'hffff_ffff, 16'hffff, 32'hffff_ffff, DIR_DECODE);
    send_item(KIND_BUILD, 8'h81, 1'b0, 1'b1);
    send_item(KIND_DATA, 8'hff, 1'b1, 1'b1);
    send_item(KIND_DATA, 8'h00, 1'b1, 1'b1);

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      write_all_regs($urandom, 16'($urandom_range(0, 48)), $urandom,
                     logic'($urandom_range(1)));
      send_item(KIND_BUILD, 8'($urandom_range(255)), logic'($urandom_range(1)),
                logic'($urandom_range(1)));
      // long receiver hold-off while the sender keeps offering
      if (ph % 4 == 0) hold_req++;
      while (items_sent < DIRECTED_ITEMS + (ph + 1) * (ITEM_TARGET - DIRECTED_ITEMS)
                          / RANDOM_PHASES) begin
        pick = $urandom_range(99);
        if (pick < 3)
          send_item(KIND_BUILD, 8'($urandom_range(255)), logic'($urandom_range(1)),
                    logic'($urandom_range(1)));
        else if (pick < 5)
          drain_results();
        else
          send_message();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("covered %0d input transfers, %0d of them table builds, %0d results checked",
             items_sent, builds_sent, results_checked);
    $display("both directions, seed and iteration extremes, all idle and stall mixes");
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: lcg_substitution_byte_cipher.f
sv/lcgsbc_pkg.sv
sv/lcgsbc_ram.sv
sv/lcgsbc_lcg.sv
sv/lcgsbc_ctrl.sv
sv/lcg_substitution_byte_cipher.sv
verif/lcgsbc_checker.sv
verif/tb_top.sv
